// File: rtl/core/b64enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Base64 encoder package
// Shared group descriptor, character constants and the standard alphabet.
// ============================================================================
package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] DIGIT_0    = 8'h30;

    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  nbytes;
        logic        eom;
    } t_group;

    function automatic logic [7:0] b64_char(input logic [5:0] slice);
        logic [7:0] code;
        case (slice) inside
            [6'd0:6'd25]:  code = UPPER_A + {2'b00, slice};
            [6'd26:6'd51]: code = LOWER_A + {2'b00, slice} - 8'd26;
            [6'd52:6'd61]: code = DIGIT_0 + {2'b00, slice} - 8'd52;
            6'd62:         code = PLUS_CHAR;
            default:       code = SLASH_CHAR;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/b64enc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Base64 encoder front end
// Collects bytes into groups of three and issues a group on the third byte or
// on the final byte of a message, left-aligned and zero-filled.
// ============================================================================
module b64enc_front
    import b64enc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_end_of_message,
    input  wire         i_q_ready,
    output logic        o_push,
    output t_group      o_entry
);

    logic [15:0] r_held_bytes, n_held_bytes;
    logic [1:0]  r_held_count, n_held_count;
    logic        w_accept;
    logic        w_close;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_close    = (r_held_count >= 2'd2) || i_end_of_message;
    assign o_push     = w_accept && w_close;

    always_comb begin
        o_entry.eom = i_end_of_message;
        if (r_held_count >= 2'd2) begin
            o_entry.group  = {r_held_bytes, i_data_byte};
            o_entry.nbytes = 2'd3;
        end else if (r_held_count == 2'd1) begin
            o_entry.group  = {r_held_bytes[7:0], i_data_byte, 8'h00};
            o_entry.nbytes = 2'd2;
        end else begin
            o_entry.group  = {i_data_byte, 16'h0000};
            o_entry.nbytes = 2'd1;
        end
    end

    always_comb begin
        n_held_bytes = r_held_bytes;
        n_held_count = r_held_count;
        if (w_accept) begin
            if (w_close) begin
                n_held_bytes = 16'h0000;
                n_held_count = 2'd0;
            end else begin
                n_held_bytes = {r_held_bytes[7:0], i_data_byte};
                n_held_count = r_held_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= 16'h0000;
            r_held_count <= 2'd0;
        end else begin
            r_held_bytes <= n_held_bytes;
            r_held_count <= n_held_count;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/b64enc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Base64 encoder group queue
// Small FIFO of pending groups between the front end and the character
// generator.
// ============================================================================
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_push,
    input  t_group                         i_entry,
    output logic                           o_ready,
    output logic                           o_valid,
    output t_group                         o_entry,
    input  wire                            i_pop,
    output logic [$clog2(DEPTH + 1) - 1:0] o_level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    t_group           r_slots [DEPTH];
    logic [PW - 1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW - 1:0]  r_rd_ptr, n_rd_ptr;
    logic [LW - 1:0]  r_level, n_level;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = (r_level != LW'(DEPTH));
    assign o_valid = (r_level != '0);
    assign o_entry = r_slots[r_rd_ptr];
    assign o_level = r_level;
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_level = r_level + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/b64enc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Base64 encoder back end
// Turns one queued group into four characters, one per cycle while the receiver
// is ready, through a registered output stage.
// ============================================================================
module b64enc_back
    import b64enc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_q_valid,
    input  t_group      i_entry,
    output logic        o_pop,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_char_code,
    output logic        o_last_char
);

    t_group      r_cur;
    logic        r_busy;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic        w_advance;
    logic [5:0]  w_slice;
    logic [7:0]  w_code;

    assign w_advance   = r_busy && (!r_out_valid || i_out_ready);
    assign o_pop       = i_q_valid && (!r_busy || (w_advance && r_idx == 2'd3));
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    always_comb begin
        case (r_idx)
            2'd0:    w_slice = r_cur.group[23:18];
            2'd1:    w_slice = r_cur.group[17:12];
            2'd2:    w_slice = r_cur.group[11:6];
            default: w_slice = r_cur.group[5:0];
        endcase
        w_code = (r_idx <= r_cur.nbytes) ? b64_char(w_slice) : PAD_CHAR;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
        if (w_advance) begin
            r_char <= w_code;
            r_last <= (r_idx == 2'd3) && r_cur.eom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_idx <= 2'd0;
            end else if (w_advance) begin
                r_idx <= r_idx + 2'd1;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_advance && r_idx == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/base64_stream_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Base64 stream encoder
// Encodes a byte stream into standard-alphabet Base64 characters with '='
// padding; the final character of each message carries o_last_char.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one message byte per
//   transaction; i_end_of_message marks the final byte of a message.
//   Output channel (o_out_valid / i_out_ready) gives one ASCII character per
//   transaction. Each group of three bytes, or the shorter group closed by
//   the final byte, yields four characters.
//   The group closed by an accepted byte is written into the queue, then
//   popped into the generator's group register; its first character is
//   then registered in the output stage. The generator issues one character
//   per cycle while the receiver is ready, so sustained input is bounded by
//   the output stage at four characters per three bytes. Bytes that do not
//   close a group are taken at one per cycle while the queue has room.
//   A stalled receiver holds the output register; the queue (QUEUE_DEPTH
//   groups) then fills and o_in_ready drops.
//   Reset clears the held bytes, the queue and the output stage; the next
//   byte starts a new message.
// ============================================================================
module base64_stream_encoder
    import b64enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_end_of_message,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_char_code,
    output logic        o_last_char
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    t_group          w_push_entry;
    t_group          w_pop_entry;
    logic            w_push;
    logic            w_pop;
    logic            w_q_ready;
    logic            w_q_valid;
    logic [LW - 1:0] w_level;

    b64enc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_q_ready        (w_q_ready),
        .o_push           (w_push),
        .o_entry          (w_push_entry)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_entry (w_pop_entry),
        .i_pop   (w_pop),
        .o_level (w_level)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_entry     (w_pop_entry),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LW'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_ready)
        else $error("group pushed into full queue");

    a_entry_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_valid && !w_pop |=> w_q_valid)
        else $error("queued group lost");

endmodule
`default_nettype wire

// File: tb/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Base64 stream encoder testbench
// Drives byte messages through the encoder with random gaps on both channels
// and a long output stall, predicts the characters of every group and checks
// each output transaction against the oldest pending prediction.
// ============================================================================
module base64_stream_encoder_tb;
    import b64enc_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_BYTES = 380;
    localparam int N_DIRECTED = 19;

    // bit 8 marks the final byte of a message
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h100,
        9'h0FF, 9'h1FF,
        9'h0FB, 9'h0EF, 9'h1BE,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h100,
        9'h04D, 9'h061, 9'h06E, 9'h020, 9'h14D,
        9'h180,
        9'h003, 9'h0F0, 9'h101
    };

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } b64_char_t;

    class b64_char_scoreboard;
        logic [15:0] held_bytes;
        logic [1:0]  held_count;
        b64_char_t   expected_chars[$];
        int          mismatches;
        int          chars_checked;

        function new();
            held_bytes    = '0;
            held_count    = '0;
            mismatches    = 0;
            chars_checked = 0;
        endfunction

        function void note_byte(logic [7:0] data, logic eom);
            logic [23:0] group;
            logic [5:0]  slice;
            int          nbytes;
            b64_char_t   c;
            if (held_count < 2 && !eom) begin
                held_bytes = {held_bytes[7:0], data};
                held_count = held_count + 2'd1;
                return;
            end
            case (held_count)
                2'd0: begin
                    group  = {data, 16'h0000};
                    nbytes = 1;
                end
                2'd1: begin
                    group  = {held_bytes[7:0], data, 8'h00};
                    nbytes = 2;
                end
                default: begin
                    group  = {held_bytes, data};
                    nbytes = 3;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                slice = group[23 - 6 * k -: 6];
                if (k > nbytes)
                    c.code = PAD_CHAR;
                else if (slice < 6'd26)
                    c.code = UPPER_A + 8'(slice);
                else if (slice < 6'd52)
                    c.code = LOWER_A + 8'(slice - 6'd26);
                else if (slice < 6'd62)
                    c.code = DIGIT_0 + 8'(slice - 6'd52);
                else if (slice == 6'd62)
                    c.code = PLUS_CHAR;
                else
                    c.code = SLASH_CHAR;
                c.last = (k == 3) && eom;
                expected_chars.push_back(c);
            end
            held_bytes = '0;
            held_count = '0;
        endfunction

        function void check_char(logic [7:0] code, logic last);
            b64_char_t exp_c;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual 0x%02h last=%0b",
                         $time, code, last);
                mismatches++;
                return;
            end
            exp_c = expected_chars.pop_front();
            chars_checked++;
            if (code !== exp_c.code) begin
                $display("%0t: char_code mismatch: expected 0x%02h, actual 0x%02h",
                         $time, exp_c.code, code);
                mismatches++;
            end
            if (last !== exp_c.last) begin
                $display("%0t: last_char mismatch: expected %0b, actual %0b",
                         $time, exp_c.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_in_valid       = 1'b0;
    logic [7:0] i_data_byte      = 8'h00;
    logic       i_end_of_message = 1'b0;
    logic       i_out_ready      = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_char_code;
    logic       o_last_char;

    b64_char_scoreboard encoded_chars = new();

    int  idle_cycles    = 0;
    int  chars_received = 0;
    int  bytes_sent     = 0;
    int  messages_sent  = 0;
    int  longest_msg    = 0;
    bit  sender_quiet   = 1'b0;
    bit  long_hold_done = 1'b0;

    base64_stream_encoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_char_code      (o_char_code),
        .o_last_char      (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            encoded_chars.note_byte(i_data_byte, i_end_of_message);
        if (i_rst_n && o_out_valid && i_out_ready)
            encoded_chars.check_char(o_char_code, o_last_char);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic eom);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        if (eom)
            messages_sent++;
    endtask

    // receiver: random stall before each character, one long hold-off
    initial begin
        int stall;
        bit quiet;
        quiet = 1'b0;
        wait (i_rst_n);
        forever begin
            if (chars_received % 24 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            stall = quiet ? 0 : $urandom_range(0, 19);
            if (chars_received >= 90 && !long_hold_done) begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            chars_received++;
        end
    end

    initial begin
        int msg_len;
        int rand_total;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        msg_len = 0;
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (msg_len == 0)
                sender_quiet = ($urandom_range(0, 2) == 0);
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
            msg_len++;
            if (DIRECTED[i][8]) begin
                if (msg_len > longest_msg)
                    longest_msg = msg_len;
                msg_len = 0;
            end
        end

        rand_total = 0;
        while (rand_total < RAND_BYTES) begin
            if ($urandom_range(0, 9) == 0)
                msg_len = $urandom_range(10, 40);
            else
                msg_len = $urandom_range(1, 9);
            sender_quiet = ($urandom_range(0, 2) == 0);
            for (int j = 0; j < msg_len; j++)
                send_byte(8'($urandom), j == msg_len - 1);
            if (msg_len > longest_msg)
                longest_msg = msg_len;
            rand_total += msg_len;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (encoded_chars.expected_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Encoded %0d messages, %0d bytes (longest %0d), %0d characters checked",
                 messages_sent, bytes_sent, longest_msg, encoded_chars.chars_checked);
        $display("Output held off for %0d cycles once, with random gaps on both sides",
                 LONG_HOLD);
        if (encoded_chars.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/b64enc_pkg.sv
rtl/core/b64enc_front.sv
rtl/core/b64enc_queue.sv
rtl/core/b64enc_back.sv
rtl/core/base64_stream_encoder.sv
tb/base64_stream_encoder_tb.sv
